>>> rtl/greenwich_sidereal_time_defines.svh
// Assertion macros for the sidereal time block.
`ifndef GREENWICH_SIDEREAL_TIME_DEFINES_SVH
`define GREENWICH_SIDEREAL_TIME_DEFINES_SVH

`ifndef ASSERT_OFF
`define GST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GST_ASSERT(lbl, prop, msg)
`define GST_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> rtl/gst_pkg.sv
// Constants, types and helper functions of the sidereal time block.
package gst_pkg;

  localparam int JD_W           = 54;
  localparam int DATE_FRAC_BITS = 32;
  localparam int ANGLE_BITS     = 32;
  localparam int IN_TDATA_W     = ((JD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W    = ((ANGLE_BITS + 7) / 8) * 8;
  localparam int NSTG           = 9;

  localparam int DAY_W = JD_W - DATE_FRAC_BITS + 1;
  localparam int T2_W  = 23;
  localparam int T2X_W = (DAY_W + 1 > 24) ? DAY_W + 1 : 24;
  localparam int TU_W  = T2_W + 40;

  typedef struct packed {
    logic ld_part;
    logic ld_sum;
  } gst_mul_ctl_t;

  // floor(num * 2^bits / den) by restoring division, elaboration time only
  function automatic logic [63:0] recip_frac(logic [63:0] num, logic [63:0] den, int bits);
    logic [63:0] r;
    logic [63:0] q;
    r = num;
    q = '0;
    for (int i = 0; i < 64; i++) begin
      if (i < bits) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r    = r - den;
          q[0] = 1'b1;
        end
      end
    end
    return q;
  endfunction

  localparam logic [63:0] K0  = recip_frac(64'd2411054841, 64'd8640000000, 64);
  localparam logic [63:0] C1  = recip_frac(64'd8640184812866, 64'd3155760000000000, 64);
  localparam logic [63:0] K2  = recip_frac(64'd93104, 64'd86400000000, 64);
  localparam logic [63:0] K3  = recip_frac(64'd62, 64'd864000000000, 64);
  localparam logic [63:0] WF  = recip_frac(64'd17202139220413523,
                                           64'd6283185307179586477, 64);
  localparam logic [63:0] R56 = recip_frac(64'd1, 64'd73050, 56);

  localparam logic [63:0] DAY_OFFSET = 64'd2451546;
  localparam logic [63:0] KSUM       = K0 + (C1 >> 1) - C1 * DAY_OFFSET;

  localparam logic [31:0] C1_LO  = C1[31:0];
  localparam logic [23:0] C1_HI  = C1[55:32];
  localparam logic [31:0] WF_LO  = WF[31:0];
  localparam logic [23:0] WF_HI  = WF[55:32];
  localparam logic [39:0] R56_LO = R56[39:0];

  localparam logic [JD_W:0]   HALF_DAY  = (JD_W + 1)'(1) << (DATE_FRAC_BITS - 1);
  localparam logic [T2X_W-1:0] T2_OFFSET = T2X_W'(4903091);
  localparam logic [T2_W-1:0]  T2_MAX    = '1;

endpackage

>>> rtl/greenwich_sidereal_time.sv
// Top level: pipelined Greenwich mean sidereal time from a Julian date.
//
// Input stream: one Julian date per beat on in_tdata (unsigned, 22 integer
// and 32 fraction bits). Output stream: GMST as an unsigned 32-bit fraction
// of a full turn on out_tdata. One result beat per input beat, in order.
//
// Nine register stages; one beat per clock is sustained while out_tready
// stays high. The wide products are built from 32x32 partial products,
// each multiply stage followed by a summing stage, and that chain of four
// multiply levels sets the depth.
//
// Every stage has its own valid bit and loads when it is empty or its
// successor loads, so bubbles are squeezed out. When out_tready is low the
// output beat holds and stages fill up behind it; in_tready drops only when
// all stages hold data.
//
// Reset (rst_n low, synchronous) clears all valid bits; no other state.
`include "greenwich_sidereal_time_defines.svh"

module greenwich_sidereal_time (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [gst_pkg::IN_TDATA_W-1:0] in_tdata,   // [53:0] julian_date
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [gst_pkg::OUT_TDATA_W-1:0] out_tdata  // [31:0] sidereal_angle
);

  localparam int DFB = gst_pkg::DATE_FRAC_BITS;
  localparam int DW  = gst_pkg::DAY_W;

  logic [gst_pkg::NSTG-1:0] stg_v_r, stg_en;
  logic [gst_pkg::NSTG-2:0] neg_r;

  // stage 0
  logic [gst_pkg::JD_W:0]        shifted;
  logic [gst_pkg::T2X_W-1:0]     twice, t2;
  logic                          neg_nxt;
  logic [gst_pkg::T2_W-1:0]      t2mag_nxt, t2mag0_r;
  logic [DW-1:0]                 day0_r;
  logic [DFB-1:0]                frac0_r;
  // stage 1
  logic [gst_pkg::TU_W-1:0]      tu_prod;
  logic [63:0]                   tu1_r;
  logic [DW+31:0]                dclo_nxt, dclo1_r;
  logic [DW+23:0]                dchi_nxt, dchi1_r;
  logic [DFB+31:0]               eflo_nxt, eflo1_r;
  logic [DFB+23:0]               efhi_nxt, efhi1_r;
  logic [DFB-1:0]                frac1_r;
  // stage 2
  logic [DFB+55:0]               efp;
  logic [63:0]                   dc_nxt, dc2_r, ef_nxt, ef2_r, tu2_r;
  // stages 3..7
  logic [63:0]                   lin3_r, lin4_r, lin5_r, tu3_r;
  logic [63:0]                   acc6_nxt, acc6_r, acc7_r;
  logic [63:0]                   sq3, cube5, q2_5, q3_7;
  // stage 8
  logic [63:0]                   sum8;
  logic [gst_pkg::ANGLE_BITS-1:0] out_nxt, out_r;

  gst_pkg::gst_mul_ctl_t sq_ctl, cb_ctl, q3_ctl;

  always_comb begin
    stg_en[gst_pkg::NSTG-1] = !stg_v_r[gst_pkg::NSTG-1] || out_tready;
    for (int k = gst_pkg::NSTG - 2; k >= 0; k--) begin
      stg_en[k] = !stg_v_r[k] || stg_en[k+1];
    end
  end

  assign in_tready  = stg_en[0];
  assign out_tvalid = stg_v_r[gst_pkg::NSTG-1];
  assign out_tdata  = gst_pkg::OUT_TDATA_W'(out_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else begin
      if (stg_en[0]) begin
        stg_v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < gst_pkg::NSTG; k++) begin
        if (stg_en[k]) begin
          stg_v_r[k] <= stg_v_r[k-1];
        end
      end
    end
  end

  // day split and day count from J2000
  always_comb begin
    shifted   = {1'b0, in_tdata[gst_pkg::JD_W-1:0]} + gst_pkg::HALF_DAY;
    twice     = gst_pkg::T2X_W'({shifted[gst_pkg::JD_W:DFB], 1'b0});
    neg_nxt   = twice < gst_pkg::T2_OFFSET;
    t2        = neg_nxt ? gst_pkg::T2_OFFSET - twice : twice - gst_pkg::T2_OFFSET;
    t2mag_nxt = (t2 > gst_pkg::T2X_W'(gst_pkg::T2_MAX)) ? gst_pkg::T2_MAX
                                                         : t2[gst_pkg::T2_W-1:0];
  end

  // first-level products
  always_comb begin
    tu_prod  = t2mag0_r * gst_pkg::R56_LO;
    dclo_nxt = day0_r * gst_pkg::C1_LO;
    dchi_nxt = day0_r * gst_pkg::C1_HI;
    eflo_nxt = frac0_r * gst_pkg::WF_LO;
    efhi_nxt = frac0_r * gst_pkg::WF_HI;
  end

  // linear day term and rotation over elapsed time
  always_comb begin
    dc_nxt = 64'(dclo1_r) + 64'({dchi1_r, 32'b0});
    efp    = {efhi1_r, 32'b0} + (DFB + 56)'(eflo1_r);
    ef_nxt = {frac1_r, {(64 - DFB){1'b0}}} + 64'(efp[DFB+55:DFB]);
  end

  always_comb begin
    acc6_nxt = lin5_r + (q2_5 << 16);
    sum8     = neg_r[gst_pkg::NSTG-2] ? acc7_r + (q3_7 << 24) : acc7_r - (q3_7 << 24);
    out_nxt  = sum8[63 -: gst_pkg::ANGLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      day0_r   <= shifted[gst_pkg::JD_W:DFB];
      frac0_r  <= shifted[DFB-1:0];
      t2mag0_r <= t2mag_nxt;
      neg_r[0] <= neg_nxt;
    end
    for (int k = 1; k < gst_pkg::NSTG - 1; k++) begin
      if (stg_en[k]) begin
        neg_r[k] <= neg_r[k-1];
      end
    end
    if (stg_en[1]) begin
      tu1_r   <= 64'(tu_prod);
      dclo1_r <= dclo_nxt;
      dchi1_r <= dchi_nxt;
      eflo1_r <= eflo_nxt;
      efhi1_r <= efhi_nxt;
      frac1_r <= frac0_r;
    end
    if (stg_en[2]) begin
      dc2_r <= dc_nxt;
      ef2_r <= ef_nxt;
      tu2_r <= tu1_r;
    end
    if (stg_en[3]) begin
      lin3_r <= gst_pkg::KSUM + dc2_r + ef2_r;
      tu3_r  <= tu2_r;
    end
    if (stg_en[4]) begin
      lin4_r <= lin3_r;
    end
    if (stg_en[5]) begin
      lin5_r <= lin4_r;
    end
    if (stg_en[6]) begin
      acc6_r <= acc6_nxt;
    end
    if (stg_en[7]) begin
      acc7_r <= acc6_r;
    end
    if (stg_en[8]) begin
      out_r <= out_nxt;
    end
  end

  assign sq_ctl = '{ld_part: stg_en[2], ld_sum: stg_en[3]};
  assign cb_ctl = '{ld_part: stg_en[4], ld_sum: stg_en[5]};
  assign q3_ctl = '{ld_part: stg_en[6], ld_sum: stg_en[7]};

  // Tu^2
  gst_mulhi u_sq (
    .clk (clk),
    .ctl (sq_ctl),
    .a   (tu1_r),
    .b   (tu1_r),
    .hi  (sq3)
  );

  // |Tu|^3
  gst_mulhi u_cube (
    .clk (clk),
    .ctl (cb_ctl),
    .a   (sq3),
    .b   (tu3_r),
    .hi  (cube5)
  );

  // quadratic term
  gst_mulhi u_quad (
    .clk (clk),
    .ctl (cb_ctl),
    .a   (sq3),
    .b   (gst_pkg::K2),
    .hi  (q2_5)
  );

  // cubic term
  gst_mulhi u_cubic (
    .clk (clk),
    .ctl (q3_ctl),
    .a   (cube5),
    .b   (gst_pkg::K3),
    .hi  (q3_7)
  );

  `GST_ASSERT_RST(a_reset_clears, !rst_n |=> !out_tvalid, "output valid after reset")
  `GST_ASSERT(a_empty_ready, (stg_v_r == '0) |-> in_tready, "empty pipe refuses beat")
  `GST_ASSERT(a_stall_keeps, stg_v_r[7] && !stg_en[8] |=> stg_v_r[7],
              "stalled beat lost ahead of output")
  `GST_ASSERT(a_advance, stg_v_r[7] && stg_en[8] |=> out_tvalid,
              "beat did not reach output")

endmodule

>>> rtl/gst_mulhi.sv
// Two-stage 64x64 high-half multiplier built from 32x32 partial products.
module gst_mulhi (
  input  logic                  clk,
  input  gst_pkg::gst_mul_ctl_t ctl,
  input  logic [63:0]           a,
  input  logic [63:0]           b,
  output logic [63:0]           hi
);

  logic [63:0] p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic [33:0] mid_nxt;
  logic [63:0] hi_nxt, hi_r;

  always_comb begin
    p00_nxt = a[31:0]  * b[31:0];
    p01_nxt = a[31:0]  * b[63:32];
    p10_nxt = a[63:32] * b[31:0];
    p11_nxt = a[63:32] * b[63:32];
    mid_nxt = 34'(p00_r[63:32]) + 34'(p01_r[31:0]) + 34'(p10_r[31:0]);
    hi_nxt  = p11_r + 64'(p01_r[63:32]) + 64'(p10_r[63:32]) + 64'(mid_nxt[33:32]);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_part) begin
      p00_r <= p00_nxt;
      p01_r <= p01_nxt;
      p10_r <= p10_nxt;
      p11_r <= p11_nxt;
    end
    if (ctl.ld_sum) begin
      hi_r <= hi_nxt;
    end
  end

  assign hi = hi_r;

endmodule
